/* design/cwt_pkg.sv */
// Shared types, constants and helpers for the commit window tracker.
// No dependencies; every other design file imports this package.
package cwt_pkg;

    localparam int CWT_RING_BLOCKS = 16;
    localparam int CWT_BLOCK_BITS  = 32;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_COMMIT   = 2'd1,
        OP_QUERY    = 2'd2,
        OP_SNAPSHOT = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_ADDR,
        ST_RMW,
        ST_ADV,
        ST_BITS,
        ST_FIN,
        ST_SNAP_RD,
        ST_SNAP_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic        read_only;
        logic [63:0] version;
    } t_cmd;

    typedef struct packed {
        logic [63:0] result_version;
        logic        ok;
        logic        committed;
        logic [31:0] block_word;
        logic        last_block;
        logic [63:0] base_now;
        logic [63:0] last_now;
    } t_rsp;

    // Locate pipeline controls: capture offset, multiply, resolve block/bit.
    typedef struct packed {
        logic load;
        logic mul;
        logic fin;
    } t_loc_ctl;

    // Position of the lowest zero bit, 8 when the byte is all ones.
    function automatic logic [3:0] first_zero8(input logic [7:0] b);
        logic [3:0] zpos;
        zpos = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                zpos = 4'(i);
            end
        end
        return zpos;
    endfunction

endpackage

/* design/cwt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on cwt_pkg for default sizes.
module cwt_ram #(
    parameter int WIDTH = cwt_pkg::CWT_BLOCK_BITS,
    parameter int DEPTH = cwt_pkg::CWT_RING_BLOCKS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import cwt_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/cwt_locate.sv */
// Maps a bit position relative to the base block onto ring block and bit index.
// Two registered steps: reciprocal multiply for the quotient, then block wrap and
// remainder. Depends on cwt_pkg.
module cwt_locate #(
    parameter int RING_BLOCKS = cwt_pkg::CWT_RING_BLOCKS,
    parameter int BLOCK_BITS  = cwt_pkg::CWT_BLOCK_BITS
) (
    input  logic                                           i_clk,
    input  cwt_pkg::t_loc_ctl                              i_ctl,
    input  logic [$clog2((RING_BLOCKS+1)*BLOCK_BITS)-1:0]  i_pos,
    input  logic [$clog2(RING_BLOCKS)-1:0]                 i_bblk,
    output logic [$clog2(RING_BLOCKS)-1:0]                 o_blk_nxt,
    output logic [$clog2(RING_BLOCKS)-1:0]                 o_blk,
    output logic [$clog2(BLOCK_BITS)-1:0]                  o_bit
);
    import cwt_pkg::*;

    localparam int PW    = $clog2((RING_BLOCKS + 1) * BLOCK_BITS);
    localparam int AW    = $clog2(RING_BLOCKS);
    localparam int BW    = $clog2(BLOCK_BITS);
    localparam int QW    = $clog2(RING_BLOCKS + 1);
    localparam int SW    = $clog2(2 * RING_BLOCKS);
    // pos * err < 2^SH keeps floor(pos * RECIP / 2^SH) exact
    localparam int SH    = PW + BW;
    localparam int RECIP = (2 ** SH + BLOCK_BITS - 1) / BLOCK_BITS;
    localparam int MW    = SH - 2;

    logic [PW-1:0]    r_pos;
    logic [QW-1:0]    r_q;
    logic [AW-1:0]    r_blk;
    logic [BW-1:0]    r_bit;
    logic [PW+MW-1:0] prod;
    logic [SW-1:0]    sum;
    logic [SW-1:0]    wrapped;
    logic [PW-1:0]    rem;

    assign prod    = (PW+MW)'(r_pos) * (PW+MW)'(RECIP);
    assign sum     = SW'(i_bblk) + SW'(r_q);
    assign wrapped = (sum >= SW'(RING_BLOCKS)) ? sum - SW'(RING_BLOCKS) : sum;
    assign rem     = r_pos - PW'(r_q) * PW'(BLOCK_BITS);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pos <= i_pos;
        end
        if (i_ctl.mul) begin
            r_q <= prod[SH +: QW];
        end
        if (i_ctl.fin) begin
            r_blk <= wrapped[AW-1:0];
            r_bit <= rem[BW-1:0];
        end
    end

    assign o_blk_nxt = wrapped[AW-1:0];
    assign o_blk     = r_blk;
    assign o_bit     = r_bit;

endmodule

/* design/commit_window_tracker.sv */
// Commit window tracker: top level, control sequencer and base advance logic.
// Depends on cwt_pkg, cwt_ram (commit bitmap) and cwt_locate (version to block/bit).
//
// Commands are taken when start is high and busy is low, one at a time. Each
// command gives its result as a one-cycle pulse on o_strobe with o_rsp; snapshot
// gives one pulse per window block, oldest first, last_block set on the final one,
// and none at all when the window is empty. The receiver cannot stall, so every
// strobe must be captured. A start that is refused or not read-only, a refused
// commit, a commit at or below base, and a query outside the window finish
// straight from the check. A query or commit inside the window first has its
// version turned into a ring block and bit over two registered steps (a
// reciprocal multiply, then wrap and remainder); then the bitmap RAM is read
// with registered read data and, for a commit, written back. A commit of the
// version just above base adds the base advance: one RAM read per fully
// committed block skipped, then the partial block is handed to the scan and
// scanned one byte at a time; read-only start follows the same path. Snapshot
// reads the RAM and then makes one transfer for each block emitted. After
// reset all blocks read as zero at once: each block has a valid flop, so no
// clearing pass is needed.
module commit_window_tracker #(
    parameter int RING_BLOCKS = cwt_pkg::CWT_RING_BLOCKS,
    parameter int BLOCK_BITS  = cwt_pkg::CWT_BLOCK_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cwt_pkg::t_cmd i_cmd,
    output logic          o_strobe,
    output cwt_pkg::t_rsp o_rsp
);
    import cwt_pkg::*;

    localparam int AW   = $clog2(RING_BLOCKS);
    localparam int BW   = $clog2(BLOCK_BITS);
    localparam int NW   = $clog2(RING_BLOCKS + 1);
    localparam int PW   = $clog2((RING_BLOCKS + 1) * BLOCK_BITS);
    localparam int NSEG = (BLOCK_BITS + 7) / 8;
    localparam int SGW  = (NSEG > 1) ? $clog2(NSEG) : 1;
    localparam int PADW = NSEG * 8;
    localparam int RB   = RING_BLOCKS * BLOCK_BITS;

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic                   r_ro, n_ro;
    logic [63:0]            r_ver, n_ver;
    logic [63:0]            r_base, n_base;     // base_version
    logic [63:0]            r_last, n_last;     // last issued version
    logic [63:0]            r_rv, n_rv;
    logic                   r_ok, n_ok;
    logic                   r_cm, n_cm;
    logic                   r_adj, n_adj;       // version is base + 1
    logic                   r_from_mem, n_from_mem;
    logic [BW-1:0]          r_boff, n_boff;     // base mod BLOCK_BITS
    logic [AW-1:0]          r_bblk, n_bblk;     // ring block that holds base + 1
    logic [AW-1:0]          r_idx, n_idx;       // snapshot walk
    logic [BLOCK_BITS-1:0]  r_word, n_word;     // forwarded block for advance
    logic [NW-1:0]          r_n, n_n;           // whole blocks skipped
    logic [SGW-1:0]         r_seg, n_seg;       // byte under scan
    logic [RING_BLOCKS-1:0] r_vld, n_vld;       // block holds written data
    logic                   r_rd_vld;
    logic                   r_ostb, n_ostb;
    t_rsp                   r_rsp, n_rsp;

    // RAM and locate hookup
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [BLOCK_BITS-1:0]  ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [BLOCK_BITS-1:0]  ram_rdata;
    t_loc_ctl               loc_ctl;
    logic [PW-1:0]          loc_pos;
    logic [AW-1:0]          loc_blk_nxt;
    logic [AW-1:0]          loc_blk;
    logic [BW-1:0]          loc_bit;

    // ---------------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------------
    logic [BLOCK_BITS-1:0]  mem_word;
    logic [BLOCK_BITS-1:0]  word_cur;
    logic [BLOCK_BITS-1:0]  bit_mask;
    logic [BLOCK_BITS-1:0]  low_mask;
    logic [BLOCK_BITS-1:0]  snap_word;
    logic [AW-1:0]          bblk_inc;
    logic [AW-1:0]          idx_inc;
    logic [PW-1:0]          v_lo;
    logic [63:0]            span;
    logic                   win_full;
    logic [NSEG-1:0][7:0]   scan_bytes;
    logic [7:0]             byte_cur;
    logic [BW:0]            scan_t;
    logic                   scan_done;
    logic                   snap_fin;

    // Unwritten blocks read as zero.
    assign mem_word = r_rd_vld ? ram_rdata : '0;
    assign word_cur = r_from_mem ? mem_word : r_word;
    assign bit_mask = BLOCK_BITS'(1) << loc_bit;

    assign bblk_inc = (r_bblk == AW'(RING_BLOCKS - 1)) ? '0 : r_bblk + 1'b1;
    assign idx_inc  = (r_idx == AW'(RING_BLOCKS - 1)) ? '0 : r_idx + 1'b1;

    // Full test on the block-aligned window: last - (base - boff) >= ring size.
    assign span     = r_last - r_base + 64'(r_boff);
    assign win_full = (span >= 64'(RB));

    // Low bits of the version to locate; only the offset from base matters.
    always_comb begin
        unique case (r_op)
            OP_START:    v_lo = r_last[PW-1:0] + PW'(1);
            OP_SNAPSHOT: v_lo = r_last[PW-1:0];
            OP_COMMIT,
            OP_QUERY:    v_lo = r_ver[PW-1:0];
        endcase
    end
    // bit position counted from the start of the base block
    assign loc_pos = v_lo - r_base[PW-1:0] + PW'(r_boff) - PW'(1);

    // Bit scan: bits below the base offset count as committed, padding as not.
    always_comb begin
        for (int i = 0; i < BLOCK_BITS; i++) begin
            low_mask[i] = (i < int'(r_boff));
        end
    end
    assign scan_bytes = PADW'(r_word) | PADW'(low_mask);
    assign byte_cur   = scan_bytes[r_seg];
    assign scan_done  = (byte_cur != 8'hFF) || (r_seg == SGW'(NSEG - 1));
    assign scan_t     = (BW+1)'({r_seg, 3'b000}) + (BW+1)'(first_zero8(byte_cur));

    assign snap_fin  = (r_idx == loc_blk);
    assign snap_word = mem_word | (snap_fin ? bit_mask : '0);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_ro       = r_ro;
        n_ver      = r_ver;
        n_base     = r_base;
        n_last     = r_last;
        n_rv       = r_rv;
        n_ok       = r_ok;
        n_cm       = r_cm;
        n_adj      = r_adj;
        n_from_mem = r_from_mem;
        n_boff     = r_boff;
        n_bblk     = r_bblk;
        n_idx      = r_idx;
        n_word     = r_word;
        n_n        = r_n;
        n_seg      = r_seg;
        n_vld      = r_vld;
        n_ostb     = 1'b0;
        n_rsp      = r_rsp;
        ram_we     = 1'b0;
        ram_waddr  = loc_blk;
        ram_wdata  = mem_word | bit_mask;
        ram_re     = 1'b0;
        ram_raddr  = r_idx;
        loc_ctl    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_cmd.operation);
                    n_ro    = i_cmd.read_only;
                    n_ver   = i_cmd.version;
                    n_rv    = '0;
                    n_ok    = 1'b1;
                    n_cm    = 1'b0;
                    n_state = ST_CHECK;
                end
            end

            ST_CHECK: begin
                loc_ctl.load = 1'b1;
                n_adj        = (loc_pos == PW'(r_boff));
                n_idx        = r_bblk;
                unique case (r_op)
                    OP_START: begin
                        if (win_full) begin
                            n_ok    = 1'b0;
                            n_state = ST_FIN;
                        end else begin
                            n_last  = r_last + 64'd1;
                            n_rv    = r_last + 64'd1;
                            n_state = r_ro ? ST_MUL : ST_FIN;
                        end
                    end
                    OP_COMMIT: begin
                        priority if (r_ver > r_last) begin
                            n_ok    = 1'b0;
                            n_state = ST_FIN;
                        end else if (r_ver > r_base) begin
                            n_state = ST_MUL;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end
                    OP_QUERY: begin
                        priority if (r_ver <= r_base) begin
                            n_cm    = 1'b1;
                            n_state = ST_FIN;
                        end else if (r_ver > r_last) begin
                            n_state = ST_FIN;
                        end else begin
                            n_state = ST_MUL;
                        end
                    end
                    OP_SNAPSHOT: begin
                        n_state = (r_base >= r_last) ? ST_IDLE : ST_MUL;
                    end
                endcase
            end

            ST_MUL: begin
                loc_ctl.mul = 1'b1;
                n_state     = ST_ADDR;
            end

            ST_ADDR: begin
                loc_ctl.fin = 1'b1;
                ram_re      = 1'b1;
                ram_raddr   = loc_blk_nxt;
                n_state     = (r_op == OP_SNAPSHOT) ? ST_SNAP_RD : ST_RMW;
            end

            ST_RMW: begin
                if (r_op == OP_QUERY) begin
                    n_cm    = mem_word[loc_bit];
                    n_state = ST_FIN;
                end else begin
                    ram_we         = 1'b1;
                    n_vld[loc_blk] = 1'b1;
                    if (r_adj) begin
                        // forward the merged block straight into the advance
                        n_word     = ram_wdata;
                        n_from_mem = 1'b0;
                        n_n        = '0;
                        n_state    = ST_ADV;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end

            ST_ADV: begin
                if (word_cur == '1 && r_n < NW'(RING_BLOCKS)) begin
                    n_base        = r_base + 64'(BLOCK_BITS) - 64'(r_boff);
                    n_boff        = '0;
                    n_bblk        = bblk_inc;
                    n_vld[r_bblk] = 1'b0;
                    n_n           = r_n + 1'b1;
                    ram_re        = 1'b1;
                    ram_raddr     = bblk_inc;
                    n_from_mem    = 1'b1;
                end else begin
                    n_word  = word_cur;
                    n_seg   = SGW'(r_boff >> 3);
                    n_state = ST_BITS;
                end
            end

            ST_BITS: begin
                if (scan_done) begin
                    n_base = r_base + 64'(scan_t) - 64'(r_boff);
                    if (scan_t == (BW+1)'(BLOCK_BITS)) begin
                        n_boff = '0;
                        n_bblk = bblk_inc;
                    end else begin
                        n_boff = scan_t[BW-1:0];
                    end
                    n_state = ST_FIN;
                end else begin
                    n_seg = r_seg + 1'b1;
                end
            end

            ST_FIN: begin
                n_ostb              = 1'b1;
                n_rsp.result_version = r_rv;
                n_rsp.ok             = r_ok;
                n_rsp.committed      = r_cm;
                n_rsp.block_word     = '0;
                n_rsp.last_block     = 1'b1;
                n_rsp.base_now       = r_base;
                n_rsp.last_now       = r_last;
                n_state              = ST_IDLE;
            end

            ST_SNAP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
                n_state   = ST_SNAP_OUT;
            end

            ST_SNAP_OUT: begin
                n_ostb               = 1'b1;
                n_rsp.result_version = '0;
                n_rsp.ok             = 1'b1;
                n_rsp.committed      = 1'b0;
                n_rsp.block_word     = 32'(snap_word);
                n_rsp.last_block     = snap_fin;
                n_rsp.base_now       = r_base;
                n_rsp.last_now       = r_last;
                if (snap_fin) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = ST_SNAP_RD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_START;
            r_base  <= '0;
            r_last  <= '0;
            r_boff  <= '0;
            r_bblk  <= '0;
            r_vld   <= '0;
            r_ostb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_base  <= n_base;
            r_last  <= n_last;
            r_boff  <= n_boff;
            r_bblk  <= n_bblk;
            r_vld   <= n_vld;
            r_ostb  <= n_ostb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ro       <= n_ro;
        r_ver      <= n_ver;
        r_rv       <= n_rv;
        r_ok       <= n_ok;
        r_cm       <= n_cm;
        r_adj      <= n_adj;
        r_from_mem <= n_from_mem;
        r_idx      <= n_idx;
        r_word     <= n_word;
        r_n        <= n_n;
        r_seg      <= n_seg;
        r_rsp      <= n_rsp;
        if (ram_re) begin
            r_rd_vld <= r_vld[ram_raddr];
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_ostb;
    assign o_rsp    = r_rsp;

    // ---------------------------------------------------------------------
    // Submodules
    // ---------------------------------------------------------------------
    cwt_ram #(
        .WIDTH (BLOCK_BITS),
        .DEPTH (RING_BLOCKS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cwt_locate #(
        .RING_BLOCKS (RING_BLOCKS),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_locate (
        .i_clk     (i_clk),
        .i_ctl     (loc_ctl),
        .i_pos     (loc_pos),
        .i_bblk    (r_bblk),
        .o_blk_nxt (loc_blk_nxt),
        .o_blk     (loc_blk),
        .o_bit     (loc_bit)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_base_le_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= r_last)
        else $error("base passed last issued version");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last - r_base + 64'(r_boff)) <= 64'(RB))
        else $error("aligned window exceeds ring size");

    a_snap_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.last_block) |-> (r_state == ST_SNAP_RD))
        else $error("non-final transfer not followed by next snapshot read");

    a_adj_hits_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RMW && r_op != OP_QUERY && r_adj)
            |-> (loc_blk == r_bblk && loc_bit == r_boff))
        else $error("version above base located off the base bit");

endmodule

/* tb/cwt_window_checker.sv */
`timescale 1ns / 1ps
// Checker for commit_window_tracker: predicts the sliding commit window and compares results.
// Depends on cwt_pkg for the command/response structs and the ring geometry.
module cwt_window_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  cwt_pkg::t_cmd i_cmd,
    input  logic          i_strobe,
    input  cwt_pkg::t_rsp i_rsp,
    output int            o_mismatches,
    output int            o_awaited,
    output logic [63:0]   o_base_ver,
    output logic [63:0]   o_last_ver
);
    import cwt_pkg::*;

    localparam int NB = CWT_RING_BLOCKS;
    localparam int BB = CWT_BLOCK_BITS;
    localparam logic [BB-1:0] FULL_WORD = '1;

    logic [63:0]   win_base;
    logic [63:0]   win_last;
    logic [BB-1:0] win_map [NB];
    t_rsp          awaited_rsps [$];
    int            mismatches = 0;

    function automatic int ring_block(input logic [63:0] v);
        return int'(((v - 64'd1) / 64'(BB)) % 64'(NB));
    endfunction

    function automatic int ring_bit(input logic [63:0] v);
        return int'((v - 64'd1) % 64'(BB));
    endfunction

    // Skip fully committed blocks first (clearing them), then walk bits of the partial one.
    task automatic slide_base();
        int idx;
        int n;
        int off;
        idx = ring_block(win_base + 64'd1);
        n = 0;
        while (n < NB && win_map[idx] == FULL_WORD) begin
            off = int'(win_base % 64'(BB));
            win_base += 64'(BB - off);
            win_map[idx] = '0;
            idx = (idx + 1) % NB;
            n++;
        end
        off = int'(win_base % 64'(BB));
        while (off < BB && win_map[idx][off]) begin
            win_base++;
            off++;
        end
    endtask

    task automatic record_commit(input logic [63:0] v);
        win_map[ring_block(v)][ring_bit(v)] = 1'b1;
        if (v == win_base + 64'd1) begin
            slide_base();
        end
    endtask

    task automatic push_rsp(input logic [63:0] rv, input logic ok, input logic cmt,
                            input logic [31:0] word, input logic fin);
        t_rsp r;
        r.result_version = rv;
        r.ok             = ok;
        r.committed      = cmt;
        r.block_word     = word;
        r.last_block     = fin;
        r.base_now       = win_base;
        r.last_now       = win_last;
        awaited_rsps.push_back(r);
    endtask

    task automatic predict_cmd(input t_cmd c);
        logic [63:0]   aligned;
        logic [BB-1:0] word;
        int            s;
        int            e;
        int            cnt;
        case (c.operation)
            OP_START: begin
                aligned = win_base - (win_base % 64'(BB));
                if (win_last - aligned >= 64'(NB * BB)) begin
                    push_rsp(64'd0, 1'b0, 1'b0, 32'd0, 1'b1);
                end else begin
                    win_last++;
                    if (c.read_only) begin
                        record_commit(win_last);
                    end
                    push_rsp(win_last, 1'b1, 1'b0, 32'd0, 1'b1);
                end
            end
            OP_COMMIT: begin
                if (c.version > win_last) begin
                    push_rsp(64'd0, 1'b0, 1'b0, 32'd0, 1'b1);
                end else begin
                    if (c.version > win_base) begin
                        record_commit(c.version);
                    end
                    push_rsp(64'd0, 1'b1, 1'b0, 32'd0, 1'b1);
                end
            end
            OP_QUERY: begin
                if (c.version <= win_base) begin
                    push_rsp(64'd0, 1'b1, 1'b1, 32'd0, 1'b1);
                end else if (c.version > win_last) begin
                    push_rsp(64'd0, 1'b1, 1'b0, 32'd0, 1'b1);
                end else begin
                    push_rsp(64'd0, 1'b1, win_map[ring_block(c.version)][ring_bit(c.version)],
                             32'd0, 1'b1);
                end
            end
            default: begin
                // empty window: snapshot gives no transfer at all
                if (win_base < win_last) begin
                    s   = ring_block(win_base + 64'd1);
                    e   = ring_block(win_last);
                    cnt = ((e + NB - s) % NB) + 1;
                    for (int i = 0; i < cnt; i++) begin
                        word = win_map[(s + i) % NB];
                        if (i == cnt - 1) begin
                            word[ring_bit(win_last)] = 1'b1;
                        end
                        push_rsp(64'd0, 1'b1, 1'b0, word, i == cnt - 1);
                    end
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_rsp(input t_rsp got);
        t_rsp want;
        if (awaited_rsps.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none got %h", $time, got);
        end else begin
            want = awaited_rsps.pop_front();
            compare_field("result_version", want.result_version, got.result_version);
            compare_field("ok", 64'(want.ok), 64'(got.ok));
            compare_field("committed", 64'(want.committed), 64'(got.committed));
            compare_field("block_word", 64'(want.block_word), 64'(got.block_word));
            compare_field("last_block", 64'(want.last_block), 64'(got.last_block));
            compare_field("base_now", want.base_now, got.base_now);
            compare_field("last_now", want.last_now, got.last_now);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_base = '0;
            win_last = '0;
            for (int i = 0; i < NB; i++) begin
                win_map[i] = '0;
            end
            awaited_rsps.delete();
        end else begin
            // results of earlier commands drain before a new one is predicted
            if (i_strobe) begin
                check_rsp(i_rsp);
            end
            if (i_start && !i_busy) begin
                predict_cmd(i_cmd);
            end
        end
        o_mismatches = mismatches;
        o_awaited    = awaited_rsps.size();
        o_base_ver   = win_base;
        o_last_ver   = win_last;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the commit_window_tracker testbench: clock, reset, command stimulus and verdict.
// Depends on cwt_pkg, the design and cwt_window_checker, which predicts and compares.
module testbench;
    import cwt_pkg::*;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic        o_strobe;
    t_cmd        cmd_in  = '0;
    t_rsp        rsp_out;
    int          mismatches;
    int          awaited;
    logic [63:0] model_base;
    logic [63:0] model_last;
    int          burst_left = 0;  // commands left in the current back-to-back run

    always #5 i_clk = ~i_clk;

    commit_window_tracker u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (cmd_in),
        .o_strobe (o_strobe),
        .o_rsp    (rsp_out)
    );

    // Checker tracks the window; its base/last mirror steers the stimulus toward
    // versions that actually live inside the window.
    cwt_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd_in),
        .i_strobe     (o_strobe),
        .i_rsp        (rsp_out),
        .o_mismatches (mismatches),
        .o_awaited    (awaited),
        .o_base_ver   (model_base),
        .o_last_ver   (model_last)
    );

    // One command transfer. Called at a falling edge and returns at one. Start is
    // only lowered when a gap follows, so back-to-back commands keep it high.
    task automatic issue(input t_op op, input logic ro, input logic [63:0] ver);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(8, 30);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        cmd_in <= '{operation: op, read_only: ro, version: ver};
        // busy is sampled at the rising edge, before the design updates it
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // Hold off until every predicted result has come out. Always waits for a falling
    // edge before it checks, so start never drops and rises in the same step.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (awaited != 0);
    endtask

    initial begin
        logic [63:0] hold_ver;
        logic [63:0] ver;
        int          span;
        int          pick;
        t_op         op;
        logic        ro;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // ---- directed: field extremes, every op, edge cases of the window ----
        issue(OP_SNAPSHOT, 1'b0, 64'd0);          // empty window: no transfer
        issue(OP_QUERY, 1'b1, 64'd0);             // at/below base reads committed
        issue(OP_QUERY, 1'b0, '1);                // far above last
        issue(OP_COMMIT, 1'b0, 64'd0);            // at base: accepted, no change
        issue(OP_COMMIT, 1'b1, '1);               // above last: refused
        issue(OP_START, 1'b0, 64'd0);             // v1 left open
        issue(OP_START, 1'b1, '1);                // v2 committed, base stuck behind v1
        issue(OP_SNAPSHOT, 1'b1, '1);             // one block, last bit forced on
        issue(OP_QUERY, 1'b0, 64'd1);
        issue(OP_QUERY, 1'b0, 64'd2);
        issue(OP_COMMIT, 1'b0, 64'd3);            // above last
        issue(OP_COMMIT, 1'b0, 64'd1);            // closes the gap, base walks to 2
        issue(OP_COMMIT, 1'b0, 64'd1);            // below base now
        issue(OP_QUERY, 1'b0, 64'd2);
        issue(OP_SNAPSHOT, 1'b0, 64'd0);          // base == last: empty again
        issue(OP_START, 1'b1, 64'd0);             // read-only start right at base+1
        issue(OP_START, 1'b0, 64'd0);
        issue(OP_START, 1'b0, 64'd0);
        issue(OP_COMMIT, 1'b0, 64'd5);            // out of order
        issue(OP_COMMIT, 1'b0, 64'd4);            // base jumps over 4 and 5
        issue(OP_QUERY, 1'b0, 64'h8000_0000_0000_0000);
        drain();

        // ---- fill: pin base with one open version, then start across a few blocks ----
        hold_ver = model_last + 64'd1;
        issue(OP_START, 1'b0, 64'd0);
        for (int i = 0; i < 48; i++) begin
            // read-only at first so a whole block fills; a few late holes stop the advance
            ro = (i < 36) || ($urandom_range(0, 9) != 0);
            issue(OP_START, ro, {$urandom, $urandom});
        end
        issue(OP_SNAPSHOT, 1'b0, 64'd0);          // several blocks emitted
        issue(OP_QUERY, 1'b0, hold_ver);
        drain();
        issue(OP_COMMIT, 1'b0, hold_ver);         // base sweeps a whole block
        issue(OP_SNAPSHOT, 1'b0, 64'd0);
        drain();

        // ---- random: mostly well-formed traffic inside the window, some noise ----
        for (int n = 0; n < 36; n++) begin
            span = int'(model_last - model_base);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                op = t_op'($urandom_range(0, 3));
                issue(op, 1'($urandom_range(0, 1)), {$urandom, $urandom});
            end else if (pick < 40 && span < 400) begin
                issue(OP_START, ($urandom_range(0, 3) == 0), {$urandom, $urandom});
            end else if (pick < 70) begin
                if (span == 0 || $urandom_range(0, 9) < 3) begin
                    ver = model_base + 64'd1;     // the one that moves base
                end else begin
                    ver = model_base + 64'($urandom_range(1, span));
                end
                issue(OP_COMMIT, 1'($urandom_range(0, 1)), ver);
            end else if (pick < 88) begin
                ver = model_base + 64'($urandom_range(0, span + 2)) - 64'd1;
                issue(OP_QUERY, 1'($urandom_range(0, 1)), ver);
            end else begin
                issue(OP_SNAPSHOT, 1'($urandom_range(0, 1)), {$urandom, $urandom});
            end
            if ($urandom_range(0, 29) == 0) begin
                drain();
            end
        end

        // ---- wind down: wait out every result, then the longest snapshot ----
        drain();
        repeat (60) @(negedge i_clk);
        if (mismatches == 0 && awaited == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run (about 110 commands).
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
